### sv/rrc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rectangle raster canvas.
// No dependencies; every other file of the block but rrc_ram imports this package.
package rrc_pkg;

   // canvas geometry
   localparam int MAX_DIM_DEF  = 256;
   localparam int FRAC_W       = 8;
   localparam int FIELD_W      = 19;
   localparam int COORD_W      = 24;   // holds any bound and any pixel position
   localparam int CFG_DIM_W    = 9;
   localparam int CHAR_W       = 8;
   localparam int RD_IDX_W     = 8;

   // register file
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam logic [CFG_DIM_W-1:0] DIM_RESET = CFG_DIM_W'(256);
   localparam logic [CHAR_W-1:0]    BG_RESET  = CHAR_W'(32);

   localparam logic signed [COORD_W-1:0] FIX_ONE = COORD_W'(256);

   typedef enum logic [1:0] {
      REG_CANVAS_WIDTH    = 2'd0,
      REG_CANVAS_HEIGHT   = 2'd1,
      REG_BACKGROUND_CHAR = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_SIZE   = 2'd1,
      STAT_OFF_CANVAS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ROW,
      ST_CELL,
      ST_RD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] width;
      logic [CFG_DIM_W-1:0] height;
      logic [CHAR_W-1:0]    bg;
   } cfg_type;

   // one axis of the rectangle, in fixed point
   typedef struct packed {
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W-1:0] hi;
      logic signed [COORD_W-1:0] lo_edge;
      logic signed [COORD_W-1:0] hi_edge;
   } span_bounds_type;

   typedef struct packed {
      logic in_span;
      logic near;
   } span_flags_type;

endpackage

### sv/rrc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command and result words.
// Depends on rrc_pkg for field widths.
interface rrc_req_if;
   import rrc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 command;
   logic                       solid;
   logic signed [FIELD_W-1:0]  left_x;
   logic signed [FIELD_W-1:0]  top_y;
   logic signed [FIELD_W-1:0]  rect_width;
   logic signed [FIELD_W-1:0]  rect_height;
   logic [CHAR_W-1:0]          paint_char;
   logic [RD_IDX_W-1:0]        read_row;
   logic [RD_IDX_W-1:0]        read_col;

   modport source (output valid, command, solid, left_x, top_y, rect_width, rect_height,
                   paint_char, read_row, read_col, input ready);
   modport sink   (input valid, command, solid, left_x, top_y, rect_width, rect_height,
                   paint_char, read_row, read_col, output ready);
endinterface

interface rrc_rsp_if;
   import rrc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [CHAR_W-1:0] cell_char;

   modport source (output valid, status, cell_char, input ready);
   modport sink   (input valid, status, cell_char, output ready);
endinterface

### sv/rect_raster_canvas_core.sv
`timescale 1ns / 1ps
// Rectangle raster canvas: top level with command sequencer, canvas RAM,
// shared span compare unit and register file. Depends on rrc_pkg, rrc_if, rrc_ram,
// rrc_span_unit and rrc_csr.
//
// A character canvas of up to MAX_DIM x MAX_DIM cells held in one RAM.
// Commands arrive one word at a time on req_ch; each gives exactly one word on
// rsp_ch. The block takes one command at a time and drops req_ch.ready until
// the result word has been taken. Clear and draw sweep every cell of the
// configured canvas in raster order: for each row the shared span unit first
// tests the row (ROW state), then for each cell the same unit tests the
// column and the RAM write port takes the cell (CELL state); the sweep is
// bounded by the single RAM write port and the one span unit. A read goes
// through decode, RAM read and capture; a bad rectangle size, an off-canvas
// read, an empty canvas or an unused command answers straight from decode.
// Canvas width and height above MAX_DIM act as MAX_DIM. Cells hold garbage
// until a clear has written them. The user must write the registers only
// while the block is idle; the block itself does not enforce it.
module rect_raster_canvas_core #(
   parameter int MAX_DIM = rrc_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rrc_req_if.sink                         req_ch,
   rrc_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rrc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rrc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rrc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import rrc_pkg::*;

   localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;  // row/col index
   localparam int DCNT_W  = $clog2(MAX_DIM + 1);                   // holds MAX_DIM
   localparam int CMP_W   = (DCNT_W > CFG_DIM_W) ? DCNT_W : CFG_DIM_W;
   localparam int RCMP_W  = (CMP_W > RD_IDX_W) ? CMP_W : RD_IDX_W;
   localparam int ADDR_W  = 2 * DIM_W;
   localparam int DEPTH   = 1 << ADDR_W;

   // ---------------- registers ----------------
   cfg_type cfg;

   rrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // effective canvas size, clamped to MAX_DIM
   logic [DCNT_W-1:0] eff_w, eff_h;

   always_comb begin
      eff_w = (CMP_W'(cfg.width)  > CMP_W'(MAX_DIM)) ? DCNT_W'(MAX_DIM) : DCNT_W'(cfg.width);
      eff_h = (CMP_W'(cfg.height) > CMP_W'(MAX_DIM)) ? DCNT_W'(MAX_DIM) : DCNT_W'(cfg.height);
   end

   // ---------------- state ----------------
   state_type state_ff, state_in;

   // captured command word (payload, no reset)
   cmd_type                   cmd_ff;
   logic                      solid_ff;
   logic signed [FIELD_W-1:0] left_x_ff, top_y_ff, rect_width_ff, rect_height_ff;
   logic [CHAR_W-1:0]         paint_ff;
   logic [RD_IDX_W-1:0]       read_row_ff, read_col_ff;

   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   span_bounds_type   x_bnd_ff, x_bnd_in, y_bnd_ff, y_bnd_in;
   span_flags_type    row_flags_ff, row_flags_in;
   status_type        status_ff, status_in;
   logic [CHAR_W-1:0] cell_ff, cell_in;

   logic req_accept, rsp_accept;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_accept = rsp_ch.valid && rsp_ch.ready;

   // ---------------- shared span unit ----------------
   logic [DIM_W-1:0] span_idx;
   span_bounds_type  span_bounds;
   span_flags_type   span_flags;

   rrc_span_unit #(.MAX_DIM(MAX_DIM)) u_span (
      .idx    (span_idx),
      .bounds (span_bounds),
      .flags  (span_flags)
   );

   // ROW tests the row against y bounds, CELL tests the column against x bounds
   always_comb begin
      if (state_ff == ST_ROW) begin
         span_idx    = row_ff;
         span_bounds = y_bnd_ff;
      end else begin
         span_idx    = col_ff;
         span_bounds = x_bnd_ff;
      end
   end

   // ---------------- canvas RAM ----------------
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [CHAR_W-1:0] ram_wr_data, ram_rd_data;

   rrc_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_canvas (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_addr = {row_ff, col_ff};
   assign ram_rd_addr = {DIM_W'(read_row_ff), DIM_W'(read_col_ff)};

   // ---------------- sequencer ----------------
   logic bad_size, empty_canvas, read_off, last_col, last_row, paint_hit;

   always_comb begin
      bad_size     = rect_width_ff[FIELD_W-1]  || (rect_width_ff == '0) ||
                     rect_height_ff[FIELD_W-1] || (rect_height_ff == '0);
      empty_canvas = (eff_w == '0) || (eff_h == '0);
      read_off     = (RCMP_W'(read_row_ff) >= RCMP_W'(eff_h)) ||
                     (RCMP_W'(read_col_ff) >= RCMP_W'(eff_w));
      last_col     = (DCNT_W'(col_ff) + DCNT_W'(1)) == eff_w;
      last_row     = (DCNT_W'(row_ff) + DCNT_W'(1)) == eff_h;
      // solid: any inside pixel; outline: inside and within one unit of an edge
      paint_hit    = row_flags_ff.in_span && span_flags.in_span &&
                     (solid_ff || row_flags_ff.near || span_flags.near);
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      x_bnd_in     = x_bnd_ff;
      y_bnd_in     = y_bnd_ff;
      row_flags_in = row_flags_ff;
      status_in    = status_ff;
      cell_in      = cell_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = paint_ff;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            status_in = STAT_OK;
            cell_in   = '0;
            row_in    = '0;
            col_in    = '0;
            // rectangle bounds in fixed point
            x_bnd_in.lo      = COORD_W'(left_x_ff);
            x_bnd_in.hi      = COORD_W'(left_x_ff) + COORD_W'(rect_width_ff);
            x_bnd_in.lo_edge = COORD_W'(left_x_ff) + FIX_ONE;
            x_bnd_in.hi_edge = COORD_W'(left_x_ff) + COORD_W'(rect_width_ff) - FIX_ONE;
            y_bnd_in.lo      = COORD_W'(top_y_ff);
            y_bnd_in.hi      = COORD_W'(top_y_ff) + COORD_W'(rect_height_ff);
            y_bnd_in.lo_edge = COORD_W'(top_y_ff) + FIX_ONE;
            y_bnd_in.hi_edge = COORD_W'(top_y_ff) + COORD_W'(rect_height_ff) - FIX_ONE;
            unique case (cmd_ff)
               CMD_CLEAR: begin
                  state_in = empty_canvas ? ST_DONE : ST_ROW;
               end
               CMD_DRAW: begin
                  if (bad_size) begin
                     status_in = STAT_BAD_SIZE;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = empty_canvas ? ST_DONE : ST_ROW;
                  end
               end
               CMD_READ: begin
                  if (read_off) begin
                     status_in = STAT_OFF_CANVAS;
                     state_in  = ST_DONE;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_RD_WAIT;
                  end
               end
               CMD_NONE: begin
                  state_in = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end

         ST_ROW: begin
            row_flags_in = span_flags;
            col_in       = '0;
            state_in     = ST_CELL;
         end

         ST_CELL: begin
            if (cmd_ff == CMD_CLEAR) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = cfg.bg;
            end else begin
               ram_wr_en   = paint_hit;
            end
            if (last_col) begin
               if (last_row) begin
                  state_in = ST_DONE;
               end else begin
                  row_in   = row_ff + DIM_W'(1);
                  state_in = ST_ROW;
               end
            end else begin
               col_in = col_ff + DIM_W'(1);
            end
         end

         ST_RD_WAIT: begin
            cell_in  = ram_rd_data;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_accept) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      x_bnd_ff     <= x_bnd_in;
      y_bnd_ff     <= y_bnd_in;
      row_flags_ff <= row_flags_in;
      status_ff    <= status_in;
      cell_ff      <= cell_in;
      if (req_accept) begin
         cmd_ff         <= cmd_type'(req_ch.command);
         solid_ff       <= req_ch.solid;
         left_x_ff      <= req_ch.left_x;
         top_y_ff       <= req_ch.top_y;
         rect_width_ff  <= req_ch.rect_width;
         rect_height_ff <= req_ch.rect_height;
         paint_ff       <= req_ch.paint_char;
         read_row_ff    <= req_ch.read_row;
         read_col_ff    <= req_ch.read_col;
      end
   end

   // ---------------- channel outputs ----------------
   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = (state_ff == ST_DONE);
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.cell_char = cell_ff;
endmodule

### sv/rrc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/rrc_span_unit.sv
`timescale 1ns / 1ps
// Shared span compare: tests one pixel index against one axis of the rectangle.
// Depends on rrc_pkg.
module rrc_span_unit #(
   parameter int MAX_DIM = rrc_pkg::MAX_DIM_DEF
) (
   input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] idx,
   input  rrc_pkg::span_bounds_type                         bounds,
   output rrc_pkg::span_flags_type                          flags
);
   import rrc_pkg::*;

   localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic signed [COORD_W-1:0] pos;

   // pixel position in fixed point: idx * 256, always non-negative
   assign pos = $signed(COORD_W'({idx, {FRAC_W{1'b0}}}));

   always_comb begin
      flags.in_span = (pos >= bounds.lo) && (pos <= bounds.hi);
      flags.near    = (pos < bounds.lo_edge) || (pos > bounds.hi_edge);
   end
endmodule

### sv/rrc_csr.sv
`timescale 1ns / 1ps
// APB-style register file: canvas width, canvas height, background character.
// Depends on rrc_pkg.
module rrc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rrc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rrc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rrc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output rrc_pkg::cfg_type                cfg
);
   import rrc_pkg::*;

   logic [CFG_DIM_W-1:0] width_ff, height_ff;
   logic [CHAR_W-1:0]    bg_ff;
   logic                 wr_en;
   reg_idx_type          reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         bg_ff     <= BG_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_CANVAS_WIDTH:    width_ff  <= pwdata[CFG_DIM_W-1:0];
            REG_CANVAS_HEIGHT:   height_ff <= pwdata[CFG_DIM_W-1:0];
            REG_BACKGROUND_CHAR: bg_ff     <= pwdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CANVAS_WIDTH:    prdata = CSR_DATA_W'(width_ff);
         REG_CANVAS_HEIGHT:   prdata = CSR_DATA_W'(height_ff);
         REG_BACKGROUND_CHAR: prdata = CSR_DATA_W'(bg_ff);
         default:             prdata = '0;
      endcase
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.bg     = bg_ff;
endmodule
